// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rate limiter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define CWRL_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define CWRL_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// check the cycle after reset is seen
`define CWRL_ASSERT_RST(label, clk, rstn, cons, msg) \
    label: assert property (@(posedge clk) !(rstn) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cwrl_pkg.sv =====
// ----------------------------------------------------------------------------
// cwrl_pkg
// Types, codes and field layout shared by the congestion window rate limiter.
// ----------------------------------------------------------------------------
package cwrl_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;

    localparam int REG_W     = 16;
    localparam int SEC_W     = 8;
    localparam int ADDR_W    = 2;
    localparam int REQ_W     = 2;
    localparam int IN_TIME_W = 32;
    localparam int DEC_W     = 3;
    localparam int OUT_W     = 16;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;

    localparam int DEC_LSB   = 0;
    localparam int WIN_LSB   = DEC_LSB + DEC_W;
    localparam int THR_LSB   = WIN_LSB + OUT_W;
    localparam int QUE_LSB   = THR_LSB + OUT_W;
    localparam int SS_BIT    = QUE_LSB + OUT_W;
    localparam int THROT_BIT = SS_BIT + 1;
    localparam int DROP_LSB  = THROT_BIT + 1;
    localparam int M_USED_W  = DROP_LSB + OUT_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    localparam logic [REG_W-1:0] MAX_MSGS_RST    = 16'd100;
    localparam logic [REG_W-1:0] MAX_QUEUE_RST   = 16'd1000;
    localparam logic [REG_W-1:0] INIT_THRESH_RST = 16'd64;
    localparam logic [SEC_W-1:0] WINDOW_SECS_RST = 8'd1;
    localparam logic [REG_W-1:0] MIN_THRESH      = 16'd2;

    typedef enum logic [ADDR_W-1:0] {
        CFG_MAX_MSGS    = 2'd0,
        CFG_MAX_QUEUE   = 2'd1,
        CFG_INIT_THRESH = 2'd2,
        CFG_WINDOW_SECS = 2'd3
    } cfg_addr_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_OFFER   = 2'd0,
        REQ_SUCCESS = 2'd1,
        REQ_FAILURE = 2'd2
    } req_t;

    typedef enum logic [DEC_W-1:0] {
        DEC_NONE       = 3'd0,
        DEC_ACCEPT     = 3'd1,
        DEC_RATE_DROP  = 3'd2,
        DEC_QUEUE_DROP = 3'd3,
        DEC_DEFER      = 3'd4
    } dec_t;

    typedef struct packed {
        logic [REG_W-1:0] max_msgs;
        logic [REG_W-1:0] max_queue;
        logic [SEC_W-1:0] window_secs;
        logic             thresh_load;
        logic [REG_W-1:0] thresh_value;
    } cfg_t;

    typedef struct packed {
        dec_t             decision;
        logic [OUT_W-1:0] window_now;
        logic [OUT_W-1:0] threshold_now;
        logic [OUT_W-1:0] queued_now;
        logic             slow_start_flag;
        logic             throttled_flag;
        logic [OUT_W-1:0] drop_streak;
    } result_t;

endpackage

// ===== rtl/cwrl_cfg.sv =====
// ----------------------------------------------------------------------------
// cwrl_cfg
// Configuration registers and threshold load strobe.
// ----------------------------------------------------------------------------
module cwrl_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [cwrl_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic [cwrl_pkg::REG_W-1:0]     cfg_wdata,
    output cwrl_pkg::cfg_t                 cfg
);
    import cwrl_pkg::*;

    logic [REG_W-1:0] max_msgs_reg;
    logic [REG_W-1:0] max_queue_reg;
    logic [SEC_W-1:0] window_secs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_msgs_reg    <= MAX_MSGS_RST;
            max_queue_reg   <= MAX_QUEUE_RST;
            window_secs_reg <= WINDOW_SECS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_MAX_MSGS:    max_msgs_reg    <= cfg_wdata;
                CFG_MAX_QUEUE:   max_queue_reg   <= cfg_wdata;
                CFG_INIT_THRESH: ;
                CFG_WINDOW_SECS: window_secs_reg <= cfg_wdata[SEC_W-1:0];
            endcase
        end
    end

    always_comb begin
        cfg.max_msgs     = max_msgs_reg;
        cfg.max_queue    = max_queue_reg;
        cfg.window_secs  = window_secs_reg;
        cfg.thresh_load  = cfg_wr_en && (cfg_addr_t'(cfg_addr) == CFG_INIT_THRESH);
        cfg.thresh_value = cfg_wdata;
    end

endmodule

// ===== rtl/cwrl_state.sv =====
// ----------------------------------------------------------------------------
// cwrl_state
// Connection state registers and combinational admission / window update logic.
// ----------------------------------------------------------------------------
module cwrl_state #(
    parameter int COUNT_WIDTH = cwrl_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = cwrl_pkg::TIME_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cwrl_pkg::cfg_t                  cfg,
    input  logic                            item_en,
    input  cwrl_pkg::req_t                  req,
    input  logic [cwrl_pkg::IN_TIME_W-1:0]  now_seconds,
    output cwrl_pkg::result_t               result
);
    import cwrl_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_TWO = COUNT_WIDTH'(2);
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    logic [COUNT_WIDTH-1:0] wc_reg,    wc_next;
    logic [TIME_WIDTH-1:0]  start_reg, start_next;
    logic [COUNT_WIDTH-1:0] q_reg,     q_next;
    logic [COUNT_WIDTH-1:0] cwnd_reg,  cwnd_next;
    logic [COUNT_WIDTH-1:0] thr_reg,   thr_next;
    logic [COUNT_WIDTH-1:0] drop_reg,  drop_next;
    logic [COUNT_WIDTH-1:0] ack_reg,   ack_next;
    logic                   ss_reg,    ss_next;
    logic                   throt_reg, throt_next;

    logic [TIME_WIDTH-1:0]  now_t;
    logic [TIME_WIDTH-1:0]  elapsed;
    logic                   expired;
    logic [COUNT_WIDTH-1:0] wc_eff;
    logic                   rate_hit;
    logic                   queue_hit;
    logic [COUNT_WIDTH-1:0] half_cwnd;
    logic [COUNT_WIDTH-1:0] fail_thr;
    logic [COUNT_WIDTH-1:0] cwnd_inc;
    logic [COUNT_WIDTH-1:0] ack_inc;
    logic [COUNT_WIDTH-1:0] load_thr;
    dec_t                   dec;

    always_comb begin
        now_t     = TIME_WIDTH'(now_seconds);
        elapsed   = now_t - start_reg;
        expired   = elapsed >= TIME_WIDTH'(cfg.window_secs);
        wc_eff    = expired ? '0 : wc_reg;
        rate_hit  = CMP_W'(wc_eff) >= CMP_W'(cfg.max_msgs);
        queue_hit = CMP_W'(q_reg) >= CMP_W'(cfg.max_queue);
        half_cwnd = cwnd_reg >> 1;
        fail_thr  = (half_cwnd < CNT_TWO) ? CNT_TWO : half_cwnd;
        cwnd_inc  = sat_inc(cwnd_reg);
        ack_inc   = sat_inc(ack_reg);
        load_thr  = (cfg.thresh_value < MIN_THRESH) ? CNT_TWO
                                                    : COUNT_WIDTH'(cfg.thresh_value);

        wc_next    = wc_reg;
        start_next = start_reg;
        q_next     = q_reg;
        cwnd_next  = cwnd_reg;
        thr_next   = thr_reg;
        drop_next  = drop_reg;
        ack_next   = ack_reg;
        ss_next    = ss_reg;
        throt_next = throt_reg;
        dec        = DEC_NONE;

        if (item_en) begin
            unique case (req)
                REQ_OFFER: begin
                    if (expired) begin
                        wc_next    = '0;
                        start_next = now_t;
                    end
                    if (rate_hit || queue_hit) begin
                        dec        = rate_hit ? DEC_RATE_DROP : DEC_QUEUE_DROP;
                        throt_next = 1'b1;
                        drop_next  = sat_inc(drop_reg);
                        thr_next   = fail_thr;
                        cwnd_next  = fail_thr;
                        ss_next    = 1'b0;
                    end else if (q_reg >= cwnd_reg) begin
                        dec = DEC_DEFER;
                    end else begin
                        dec       = DEC_ACCEPT;
                        wc_next   = sat_inc(wc_eff);
                        q_next    = sat_inc(q_reg);
                        drop_next = '0;
                    end
                end
                REQ_SUCCESS: begin
                    if (ss_reg) begin
                        cwnd_next = cwnd_inc;
                        if (cwnd_inc >= thr_reg) begin
                            ss_next = 1'b0;
                        end
                    end else if (ack_inc >= cwnd_reg) begin
                        cwnd_next = cwnd_inc;
                        ack_next  = '0;
                    end else begin
                        ack_next = ack_inc;
                    end
                    if (q_reg != '0) begin
                        q_next = q_reg - CNT_ONE;
                    end
                end
                REQ_FAILURE: begin
                    thr_next  = fail_thr;
                    cwnd_next = fail_thr;
                    ss_next   = 1'b0;
                end
                default: ;
            endcase
        end

        if (cfg.thresh_load) begin
            thr_next = load_thr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg    <= '0;
            start_reg <= '0;
            q_reg     <= '0;
            cwnd_reg  <= CNT_ONE;
            thr_reg   <= COUNT_WIDTH'(INIT_THRESH_RST);
            drop_reg  <= '0;
            ack_reg   <= '0;
            ss_reg    <= 1'b1;
            throt_reg <= 1'b0;
        end else begin
            wc_reg    <= wc_next;
            start_reg <= start_next;
            q_reg     <= q_next;
            cwnd_reg  <= cwnd_next;
            thr_reg   <= thr_next;
            drop_reg  <= drop_next;
            ack_reg   <= ack_next;
            ss_reg    <= ss_next;
            throt_reg <= throt_next;
        end
    end

    always_comb begin
        result.decision        = dec;
        result.window_now      = OUT_W'(cwnd_next);
        result.threshold_now   = OUT_W'(thr_next);
        result.queued_now      = OUT_W'(q_next);
        result.slow_start_flag = ss_next;
        result.throttled_flag  = throt_next;
        result.drop_streak     = OUT_W'(drop_next);
    end

endmodule

// ===== rtl/congestion_window_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// congestion_window_rate_limiter
// Per-connection admission control with slow start and AIMD window.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one event per transaction: s_tuser is the request
//   kind (offer, delivery success, delivery failure), s_tdata the time in
//   seconds. m_ channel returns exactly one result per event: decision,
//   window, threshold, queue depth, flags and drop streak.
//   cfg_wr_en / cfg_addr / cfg_wdata write limits; write only while idle.
//   The event is held in the input register and its result in the result
//   register, which drives m_; the result register loads only when it is
//   empty or being read. Throughput: one event per cycle while the receiver
//   takes every result; the whole state update is one compare-and-increment
//   pass between the input register and the result register.
//   Reset (aresetn low, synchronous) restores default limits, cwnd of one,
//   slow start, and empties both stages.
//   When the receiver stalls, the result register holds and one more event
//   may wait in the input register; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module congestion_window_rate_limiter #(
    parameter int COUNT_WIDTH = cwrl_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = cwrl_pkg::TIME_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] now_seconds
    input  logic [cwrl_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] req_type
    input  logic [cwrl_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] decision, [18:3] window_now, [34:19] threshold_now,
    // [50:35] queued_now, [51] slow_start_flag, [52] throttled_flag,
    // [68:53] drop_streak, [71:69] zero
    output logic [cwrl_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [cwrl_pkg::ADDR_W-1:0]     cfg_addr,
    input  logic [cwrl_pkg::REG_W-1:0]      cfg_wdata
);
    import cwrl_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic                 in_valid_reg;
    logic [REQ_W-1:0]     req_reg;
    logic [IN_TIME_W-1:0] now_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;
    logic                 advance;
    logic                 fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    cwrl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cwrl_state #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_state (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .item_en     (fire),
        .req         (req_t'(req_reg)),
        .now_seconds (now_reg),
        .result      (result)
    );

    always_comb begin
        out_data_next                         = '0;
        out_data_next[DEC_LSB +: DEC_W]       = result.decision;
        out_data_next[WIN_LSB +: OUT_W]       = result.window_now;
        out_data_next[THR_LSB +: OUT_W]       = result.threshold_now;
        out_data_next[QUE_LSB +: OUT_W]       = result.queued_now;
        out_data_next[SS_BIT]                 = result.slow_start_flag;
        out_data_next[THROT_BIT]              = result.throttled_flag;
        out_data_next[DROP_LSB +: OUT_W]      = result.drop_streak;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg <= s_tuser[REQ_W-1:0];
            now_reg <= s_tdata[IN_TIME_W-1:0];
        end
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== rtl/cwrl_checker.sv =====
// ----------------------------------------------------------------------------
// cwrl_checker
// Port-level assertions for the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cwrl_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cwrl_pkg::M_TDATA_W-1:0]  m_tdata
);
    import cwrl_pkg::*;

    logic [DEC_W-1:0] dec_w;
    logic [OUT_W-1:0] drop_w;
    logic             throt_w;
    logic             is_accept;
    logic             is_drop;

    assign dec_w     = m_tdata[DEC_LSB +: DEC_W];
    assign drop_w    = m_tdata[DROP_LSB +: OUT_W];
    assign throt_w   = m_tdata[THROT_BIT];
    assign is_accept = dec_w == DEC_ACCEPT;
    assign is_drop   = (dec_w == DEC_RATE_DROP) || (dec_w == DEC_QUEUE_DROP);

    `CWRL_ASSERT_RST(a_reset_empty, aclk, aresetn, !m_tvalid,
        "result valid right after reset")

    `CWRL_ASSERT_NXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result changed")

    `CWRL_ASSERT_IMP(a_ready_backpressure, aclk, aresetn, !s_tready,
        m_tvalid && !m_tready, "input stalled without output backpressure")

    `CWRL_ASSERT_IMP(a_accept_clears_streak, aclk, aresetn, m_tvalid && is_accept,
        drop_w == '0, "accepted message with nonzero drop streak")

    `CWRL_ASSERT_IMP(a_drop_throttles, aclk, aresetn, m_tvalid && is_drop,
        throt_w, "drop without throttle flag")

endmodule

bind congestion_window_rate_limiter cwrl_checker u_cwrl_checker (.*);

// ===== tb/congestion_window_rate_limiter_checker.sv =====
// ----------------------------------------------------------------------------
// congestion_window_rate_limiter_checker
// Watches the event, result and register write ports of the rate limiter.
// Keeps its own copy of the limits and the connection state and predicts
// the result of each event as it is taken. Results are then matched in
// order, field by field, against the predictions.
// ----------------------------------------------------------------------------
module congestion_window_rate_limiter_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [cwrl_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [cwrl_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [cwrl_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [cwrl_pkg::ADDR_W-1:0]      cfg_addr,
    input  logic [cwrl_pkg::REG_W-1:0]       cfg_wdata,
    output int                               mismatches,
    output int                               results_owed
);
    import cwrl_pkg::*;

    localparam logic [OUT_W-1:0] COUNT_MAX = '1;

    logic [REG_W-1:0]     rate_limit;
    logic [REG_W-1:0]     queue_limit;
    logic [SEC_W-1:0]     window_len;

    logic [OUT_W-1:0]     window_msgs;
    logic [IN_TIME_W-1:0] window_origin;
    logic [OUT_W-1:0]     outstanding;
    logic [OUT_W-1:0]     cwnd;
    logic [OUT_W-1:0]     ssthresh;
    logic [OUT_W-1:0]     drop_run;
    logic [OUT_W-1:0]     ack_run;
    logic                 ss_active;
    logic                 throttled;

    result_t              predicted_results[$];
    int                   mismatch_count = 0;

    assign mismatches = mismatch_count;

    function automatic logic [OUT_W-1:0] bump(input logic [OUT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_W-1:0] floor_two(input logic [OUT_W-1:0] v);
        return (v < MIN_THRESH) ? MIN_THRESH : v;
    endfunction

    task automatic halve_window();
        ssthresh  = floor_two(cwnd >> 1);
        cwnd      = ssthresh;
        ss_active = 1'b0;
    endtask

    task automatic apply_register(input logic [ADDR_W-1:0] addr, input logic [REG_W-1:0] value);
        case (addr)
            CFG_MAX_MSGS:    rate_limit  = value;
            CFG_MAX_QUEUE:   queue_limit = value;
            CFG_INIT_THRESH: ssthresh    = floor_two(value);
            CFG_WINDOW_SECS: window_len  = value[SEC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_event(input logic [REQ_W-1:0] kind, input logic [IN_TIME_W-1:0] secs,
                                 output result_t r);
        dec_t verdict;
        verdict = DEC_NONE;
        case (kind)
            REQ_OFFER: begin
                if (secs - window_origin >= IN_TIME_W'(window_len)) begin
                    window_msgs   = '0;
                    window_origin = secs;
                end
                if (window_msgs >= rate_limit || outstanding >= queue_limit) begin
                    verdict   = (window_msgs >= rate_limit) ? DEC_RATE_DROP : DEC_QUEUE_DROP;
                    throttled = 1'b1;
                    drop_run  = bump(drop_run);
                    halve_window();
                end else if (outstanding >= cwnd) begin
                    verdict = DEC_DEFER;
                end else begin
                    window_msgs = bump(window_msgs);
                    outstanding = bump(outstanding);
                    drop_run    = '0;
                    verdict     = DEC_ACCEPT;
                end
            end
            REQ_SUCCESS: begin
                if (ss_active) begin
                    cwnd = bump(cwnd);
                    if (cwnd >= ssthresh) ss_active = 1'b0;
                end else begin
                    ack_run = bump(ack_run);
                    if (ack_run >= cwnd) begin
                        cwnd    = bump(cwnd);
                        ack_run = '0;
                    end
                end
                if (outstanding != '0) outstanding = outstanding - 1'b1;
            end
            REQ_FAILURE: halve_window();
            default: ;
        endcase
        r.decision        = verdict;
        r.window_now      = cwnd;
        r.threshold_now   = ssthresh;
        r.queued_now      = outstanding;
        r.slow_start_flag = ss_active;
        r.throttled_flag  = throttled;
        r.drop_streak     = drop_run;
    endtask

    task automatic check_field(input string label, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            rate_limit    = MAX_MSGS_RST;
            queue_limit   = MAX_QUEUE_RST;
            window_len    = WINDOW_SECS_RST;
            window_msgs   = '0;
            window_origin = '0;
            outstanding   = '0;
            cwnd          = 16'd1;
            ssthresh      = floor_two(INIT_THRESH_RST);
            drop_run      = '0;
            ack_run       = '0;
            ss_active     = 1'b1;
            throttled     = 1'b0;
            predicted_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                end else begin
                    want = predicted_results.pop_front();
                    check_field("decision", 32'(want.decision),
                                32'(m_tdata[DEC_LSB +: DEC_W]));
                    check_field("window_now", 32'(want.window_now),
                                32'(m_tdata[WIN_LSB +: OUT_W]));
                    check_field("threshold_now", 32'(want.threshold_now),
                                32'(m_tdata[THR_LSB +: OUT_W]));
                    check_field("queued_now", 32'(want.queued_now),
                                32'(m_tdata[QUE_LSB +: OUT_W]));
                    check_field("slow_start_flag", 32'(want.slow_start_flag),
                                32'(m_tdata[SS_BIT]));
                    check_field("throttled_flag", 32'(want.throttled_flag),
                                32'(m_tdata[THROT_BIT]));
                    check_field("drop_streak", 32'(want.drop_streak),
                                32'(m_tdata[DROP_LSB +: OUT_W]));
                    check_field("padding", 32'd0, 32'(m_tdata[M_TDATA_W-1:M_USED_W]));
                end
            end
            if (cfg_wr_en) apply_register(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready) begin
                predict_event(s_tuser, s_tdata, want);
                predicted_results.push_back(want);
            end
        end
        results_owed <= predicted_results.size();
    end

endmodule

// ===== tb/congestion_window_rate_limiter_test.sv =====
// ----------------------------------------------------------------------------
// congestion_window_rate_limiter_test
// Drives offered messages, delivery successes and failures into the rate
// limiter: a short directed run over the limits, wrap-around of time and
// the corner cases, then random events under several register settings
// with random gaps on both channels. A checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module congestion_window_rate_limiter_test;
    import cwrl_pkg::*;

    localparam int LATENCY      = 2;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int SEGMENTS     = 6;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [ADDR_W-1:0]     cfg_addr  = '0;
    logic [REG_W-1:0]      cfg_wdata = '0;

    int                    send_idle_pct = 19;
    int                    recv_idle_pct = 75;
    int                    stall_cycles  = 0;
    int                    mismatch_total;
    int                    results_owed;
    logic [IN_TIME_W-1:0]  clock_secs    = '0;

    congestion_window_rate_limiter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    congestion_window_rate_limiter_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatch_total),
        .results_owed (results_owed)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_event(input logic [REQ_W-1:0] kind, input logic [IN_TIME_W-1:0] secs);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= secs;
        do @(posedge aclk); while (!s_tready);
    endtask

    // drain all results, then let the pipeline settle
    task automatic quiesce();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic configure(input logic [REG_W-1:0] msgs, input logic [REG_W-1:0] depth,
                             input logic [REG_W-1:0] thresh, input logic [REG_W-1:0] secs);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_MAX_MSGS;
        cfg_wdata <= msgs;
        @(posedge aclk);
        cfg_addr  <= CFG_MAX_QUEUE;
        cfg_wdata <= depth;
        @(posedge aclk);
        cfg_addr  <= CFG_INIT_THRESH;
        cfg_wdata <= thresh;
        @(posedge aclk);
        cfg_addr  <= CFG_WINDOW_SECS;
        cfg_wdata <= secs;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_event();
        int pick;
        int step;
        logic [REQ_W-1:0] kind;
        pick = $urandom_range(0, 99);
        step = $urandom_range(0, 99);
        if (pick < 3) kind = REQ_UNUSED;
        else if (pick < 11) kind = REQ_FAILURE;
        else if (pick < 50) kind = REQ_SUCCESS;
        else kind = REQ_OFFER;
        if (step >= 97) clock_secs = $urandom();
        else if (step >= 90) clock_secs = clock_secs + $urandom_range(2, 300);
        else if (step >= 60) clock_secs = clock_secs + 1'b1;
        send_event(kind, (kind == REQ_OFFER) ? clock_secs : $urandom());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_event(REQ_OFFER, 32'h0000_0000);
        send_event(REQ_OFFER, 32'h0000_0000);
        send_event(REQ_SUCCESS, 32'hFFFF_FFFF);
        send_event(REQ_SUCCESS, 32'h0000_0000);
        send_event(REQ_UNUSED, 32'h5555_5555);
        send_event(REQ_OFFER, 32'hFFFF_FFFF);
        send_event(REQ_OFFER, 32'h0000_0000);
        send_event(REQ_FAILURE, 32'hAAAA_AAAA);
        send_event(REQ_OFFER, 32'hAAAA_AAAA);
        send_event(REQ_OFFER, 32'h5555_5555);
        repeat (3) send_event(REQ_SUCCESS, 32'h0000_0000);

        quiesce();
        configure(16'd0, 16'd1000, 16'd1, 16'd0);
        send_event(REQ_OFFER, 32'h0000_0000);
        send_event(REQ_OFFER, 32'h0000_0000);
        send_event(REQ_FAILURE, 32'h0000_0000);

        quiesce();
        configure(16'd5, 16'd0, 16'hFFFF, 16'd255);
        send_event(REQ_OFFER, 32'h0000_0000);
        send_event(REQ_OFFER, 32'd100);

        quiesce();
        configure(16'hFFFF, 16'hFFFF, 16'd2, 16'd1);
        repeat (3) send_event(REQ_SUCCESS, 32'h0000_0000);
        send_event(REQ_OFFER, 32'd10);
        send_event(REQ_OFFER, 32'd10);
        send_event(REQ_OFFER, 32'd11);
        send_event(REQ_FAILURE, 32'h0000_0000);
        send_event(REQ_SUCCESS, 32'h0000_0000);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            quiesce();
            case (seg / 2)
                0: begin send_idle_pct = 19; recv_idle_pct = 75; end
                1: begin send_idle_pct = 75; recv_idle_pct = 19; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (seg)
                0: configure(MAX_MSGS_RST, MAX_QUEUE_RST, INIT_THRESH_RST,
                             REG_W'(WINDOW_SECS_RST));
                1: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255);
                2: configure(16'd1, 16'd1, 16'd2, 16'd1);
                3: configure(REG_W'($urandom_range(0, 4)), REG_W'($urandom_range(0, 10)),
                             REG_W'($urandom_range(0, 3)), 16'd0);
                4: configure(REG_W'($urandom_range(1, 20)), REG_W'($urandom_range(1, 40)),
                             REG_W'($urandom_range(2, 30)), REG_W'($urandom_range(1, 8)));
                default: configure(REG_W'($urandom_range(0, 65535)),
                                   REG_W'($urandom_range(0, 65535)),
                                   REG_W'($urandom_range(0, 65535)),
                                   REG_W'($urandom_range(0, 255)));
            endcase
            repeat (RANDOM_ITEMS / SEGMENTS) random_event();
        end

        quiesce();
        if (mismatch_total == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
